FILE: src/cat_pkg.sv
package cat_pkg;

   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic [ACTION_W-1:0] ACT_APPEND    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DEL_VALUE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DEL_INDEX = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_READ      = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_PTR,
      RD_PTR1,
      RD_PTR2
   } rd_sel_type;

   typedef enum logic {
      WR_TAIL,
      WR_PTR
   } wr_sel_type;

   typedef enum logic [1:0] {
      PTR_HOLD,
      PTR_CLEAR,
      PTR_LOAD,
      PTR_INC
   } ptr_op_type;

   typedef struct packed {
      logic                capture;
      logic                rd_en;
      rd_sel_type          rd_sel;
      logic                wr_en;
      wr_sel_type          wr_sel;
      ptr_op_type          ptr_op;
      logic                cnt_inc;
      logic                cnt_dec;
      logic                rsp_valid;
      logic [STATUS_W-1:0] rsp_status;
      logic                rsp_read;
   } cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                full;
      logic                empty;
      logic                idx_oob;
      logic                match;
      logic                next_in;
      logic                next2_in;
   } sts_type;

endpackage

FILE: src/cat_ctrl.sv
module cat_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cat_pkg::sts_type sts,
   output cat_pkg::cmd_type cmd
);
   import cat_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_RD_WAIT  = 3'd2;
   localparam logic [2:0] S_SEARCH   = 3'd3;
   localparam logic [2:0] S_SH_FETCH = 3'd4;
   localparam logic [2:0] S_SH_MOVE  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               cmd.ptr_op  = PTR_CLEAR;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.action)
               ACT_APPEND: begin
                  cmd.rsp_valid = 1'b1;
                  state_in      = S_IDLE;
                  if (sts.full) begin
                     cmd.rsp_status = ST_FULL;
                  end else begin
                     cmd.wr_en      = 1'b1;
                     cmd.wr_sel     = WR_TAIL;
                     cmd.cnt_inc    = 1'b1;
                     cmd.rsp_status = ST_OK;
                  end
               end
               ACT_DEL_VALUE: begin
                  if (sts.empty) begin
                     cmd.rsp_valid  = 1'b1;
                     cmd.rsp_status = ST_MISSING;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_PTR;
                     state_in   = S_SEARCH;
                  end
               end
               ACT_DEL_INDEX: begin
                  if (sts.idx_oob) begin
                     cmd.rsp_valid  = 1'b1;
                     cmd.rsp_status = ST_RANGE;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.ptr_op = PTR_LOAD;
                     state_in   = S_SH_FETCH;
                  end
               end
               ACT_READ: begin
                  if (sts.idx_oob) begin
                     cmd.rsp_valid  = 1'b1;
                     cmd.rsp_status = ST_RANGE;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_IDX;
                     state_in   = S_RD_WAIT;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_RD_WAIT: begin
            cmd.rsp_valid  = 1'b1;
            cmd.rsp_status = ST_OK;
            cmd.rsp_read   = 1'b1;
            state_in       = S_IDLE;
         end
         S_SEARCH: begin
            // The compared word is the entry at the pointer; the next one is fetched ahead.
            if (sts.match) begin
               state_in = S_SH_FETCH;
            end else if (!sts.next_in) begin
               cmd.rsp_valid  = 1'b1;
               cmd.rsp_status = ST_MISSING;
               state_in       = S_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PTR1;
               cmd.ptr_op = PTR_INC;
            end
         end
         S_SH_FETCH: begin
            if (!sts.next_in) begin
               cmd.cnt_dec    = 1'b1;
               cmd.rsp_valid  = 1'b1;
               cmd.rsp_status = ST_OK;
               state_in       = S_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PTR1;
               state_in   = S_SH_MOVE;
            end
         end
         S_SH_MOVE: begin
            // Write the entry fetched last cycle one place down and fetch the one after it.
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_PTR;
            cmd.ptr_op = PTR_INC;
            if (sts.next2_in) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PTR2;
            end else begin
               cmd.cnt_dec    = 1'b1;
               cmd.rsp_valid  = 1'b1;
               cmd.rsp_status = ST_OK;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but controller did not go busy");

   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_valid |=> !busy)
      else $error("controller still busy after issuing a response");

   a_rsp_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_valid |-> busy)
      else $error("response issued while the controller was idle");

endmodule

FILE: src/cat_datapath.sv
module cat_datapath #(
   parameter int DEPTH      = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cat_pkg::ACTION_W-1:0]        req_action,
   input  logic [cat_pkg::VALUE_W-1:0]         req_value,
   input  logic [cat_pkg::INDEX_W-1:0]         req_index,
   input  cat_pkg::cmd_type                    cmd,
   output cat_pkg::sts_type                    sts,
   output logic                                rsp_valid,
   output logic [cat_pkg::VALUE_W-1:0]         rsp_read_value,
   output logic [cat_pkg::STATUS_W-1:0]        rsp_status,
   output logic [cat_pkg::COUNT_W-1:0]         rsp_count
);
   import cat_pkg::*;

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW + 1 > INDEX_W + 1) ? CW + 1 : INDEX_W + 1;

   logic [ELEM_WIDTH-1:0] store_ff [DEPTH];

   logic [ACTION_W-1:0]   action_ff;
   logic [ELEM_WIDTH-1:0] val_ff;
   logic [ELEM_WIDTH-1:0] val_in;
   logic [INDEX_W-1:0]    idx_ff;
   logic [AW-1:0]         ptr_ff;
   logic [AW-1:0]         ptr_in;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic [ELEM_WIDTH-1:0] rdata_ff;

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [VALUE_W-1:0]    rsp_read_value_ff;
   logic [VALUE_W-1:0]    rsp_read_value_in;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic [63:0]           req_value_wide;
   logic [63:0]           rdata_wide;
   logic [CMPW-1:0]       count_ext;
   logic [CMPW-1:0]       idx_ext;
   logic [CMPW-1:0]       ptr_ext;
   logic [CMPW-1:0]       ptr1_ext;
   logic [CMPW-1:0]       ptr2_ext;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         wr_addr;
   logic [ELEM_WIDTH-1:0] wr_data;

   assign req_value_wide = {32'b0, req_value};
   assign val_in         = req_value_wide[ELEM_WIDTH-1:0];
   assign rdata_wide     = 64'(rdata_ff);

   assign count_ext = CMPW'(count_ff);
   assign idx_ext   = CMPW'(idx_ff);
   assign ptr_ext   = CMPW'(ptr_ff);
   assign ptr1_ext  = ptr_ext + CMPW'(1);
   assign ptr2_ext  = ptr_ext + CMPW'(2);

   always_comb begin
      sts.action   = action_ff;
      sts.full     = (count_ff == CW'(DEPTH));
      sts.empty    = (count_ff == '0);
      sts.idx_oob  = (idx_ext >= count_ext);
      sts.match    = (rdata_ff == val_ff);
      sts.next_in  = (ptr1_ext < count_ext);
      sts.next2_in = (ptr2_ext < count_ext);
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_IDX:  rd_addr = idx_ext[AW-1:0];
         RD_PTR:  rd_addr = ptr_ff;
         RD_PTR1: rd_addr = ptr1_ext[AW-1:0];
         RD_PTR2: rd_addr = ptr2_ext[AW-1:0];
         default: rd_addr = ptr_ff;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         WR_TAIL: begin
            wr_addr = count_ext[AW-1:0];
            wr_data = val_ff;
         end
         WR_PTR: begin
            wr_addr = ptr_ff;
            wr_data = rdata_ff;
         end
         default: begin
            wr_addr = ptr_ff;
            wr_data = rdata_ff;
         end
      endcase
   end

   always_comb begin
      case (cmd.ptr_op)
         PTR_HOLD:  ptr_in = ptr_ff;
         PTR_CLEAR: ptr_in = '0;
         PTR_LOAD:  ptr_in = idx_ext[AW-1:0];
         PTR_INC:   ptr_in = ptr_ff + AW'(1);
         default:   ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign rsp_read_value_in = cmd.rsp_read ? rdata_wide[VALUE_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         val_ff    <= val_in;
         idx_ff    <= req_index;
      end
      ptr_ff <= ptr_in;
      if (cmd.rsp_valid) begin
         rsp_status_ff     <= cmd.rsp_status;
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_count_ff      <= COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.rsp_valid;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMPW'(count_ff) <= CMPW'(DEPTH))
      else $error("element count exceeds capacity");

   a_count_moves_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> rsp_valid_ff)
      else $error("element count changed without a response");

   a_failed_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> $stable(count_ff))
      else $error("failed request changed the element count");

   a_rw_apart: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && cmd.rd_en) |-> (wr_addr != rd_addr))
      else $error("store read and written at the same address");

endmodule

FILE: src/compacting_array_table.sv
// Packed list of up to DEPTH elements with a count, held in an internal store.
// Requests: present req_action, req_value and req_index with start high; the
// request is taken at a rising edge where start is high and busy is low.
// Actions are append, delete first match of value, delete at index and read
// at index. Every request gives exactly one result: rsp_valid is high for one
// cycle with rsp_read_value, rsp_status and rsp_count (the count after the
// request). The receiver cannot stall; the result must be taken in that cycle.
// A delete walks the store through its single read port and single write port,
// one entry per cycle: a delete by value searches for its first match and then
// shifts the later entries down one place; a delete at index shifts down the
// entries above the index.
// busy falls in the cycle the result is shown, and a new request may be given
// in that same cycle. One request is in flight at a time.
// Reset empties the list at once; the store itself is not cleared, as only
// entries below the count are ever read.
module compacting_array_table #(
   parameter int DEPTH      = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [cat_pkg::ACTION_W-1:0] req_action,
   input  logic [cat_pkg::VALUE_W-1:0]  req_value,
   input  logic [cat_pkg::INDEX_W-1:0]  req_index,
   output logic                         rsp_valid,
   output logic [cat_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic [cat_pkg::STATUS_W-1:0] rsp_status,
   output logic [cat_pkg::COUNT_W-1:0]  rsp_count
);
   import cat_pkg::*;

   cmd_type cmd;
   sts_type sts;

   cat_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   cat_datapath #(
      .DEPTH      (DEPTH),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_action     (req_action),
      .req_value      (req_value),
      .req_index      (req_index),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

endmodule

FILE: tb/compacting_array_table_tb.sv
module compacting_array_table_tb;
   import cat_pkg::*;

   localparam int LIST_DEPTH   = 64;
   localparam int RANDOM_ITEMS = 610;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = LIST_DEPTH + 8;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [VALUE_W-1:0]  value;
      logic [INDEX_W-1:0]  idx;
   } request_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  read_value;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } list_result_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                start      = 1'b0;
   logic [ACTION_W-1:0] req_action = ACT_APPEND;
   logic [VALUE_W-1:0]  req_value  = '0;
   logic [INDEX_W-1:0]  req_index  = '0;
   logic                busy;
   logic                rsp_valid;
   logic [VALUE_W-1:0]  rsp_read_value;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_count;

   request_type     pending_reqs[$];
   list_result_type expected_results[$];
   logic [VALUE_W-1:0] shadow_list[$];
   logic [VALUE_W-1:0] value_pool[8];

   logic [VALUE_W-1:0] model_store[LIST_DEPTH];
   logic [COUNT_W-1:0] model_count = '0;

   int total_reqs  = 0;
   int sent_reqs   = 0;
   int error_count = 0;
   int idle_cycles = 0;

   compacting_array_table #(
      .DEPTH      (LIST_DEPTH),
      .ELEM_WIDTH (VALUE_W)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_value      (req_value),
      .req_index      (req_index),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Queue a request and keep a shadow of the list so that later requests
   // can be steered toward present values and valid positions.
   task automatic add_request(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val,
                              input logic [INDEX_W-1:0] pos);
      request_type r;
      int          k;
      r.action = act;
      r.value  = val;
      r.idx    = pos;
      pending_reqs.push_back(r);
      case (act)
         ACT_APPEND: if (shadow_list.size() < LIST_DEPTH) shadow_list.push_back(val);
         ACT_DEL_VALUE: begin
            for (k = 0; k < shadow_list.size(); k++)
               if (shadow_list[k] == val) break;
            if (k < shadow_list.size()) shadow_list.delete(k);
         end
         ACT_DEL_INDEX: if (int'(pos) < shadow_list.size()) shadow_list.delete(int'(pos));
         default: ;
      endcase
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      if ($urandom_range(9) < 7) return value_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   task automatic close_gap(input int pos);
      int k;
      for (k = pos; k + 1 < int'(model_count); k++)
         model_store[k] = model_store[k + 1];
      model_count = model_count - COUNT_W'(1);
   endtask

   task automatic predict_result(input request_type r);
      list_result_type e;
      int              k;
      e.read_value = '0;
      e.status     = ST_OK;
      case (r.action)
         ACT_APPEND: begin
            if (int'(model_count) >= LIST_DEPTH) begin
               e.status = ST_FULL;
            end else begin
               model_store[model_count] = r.value;
               model_count = model_count + COUNT_W'(1);
            end
         end
         ACT_DEL_VALUE: begin
            for (k = 0; k < int'(model_count); k++)
               if (model_store[k] == r.value) break;
            if (k >= int'(model_count)) e.status = ST_MISSING;
            else close_gap(k);
         end
         ACT_DEL_INDEX: begin
            if (int'(r.idx) >= int'(model_count)) e.status = ST_RANGE;
            else close_gap(int'(r.idx));
         end
         default: begin
            if (int'(r.idx) >= int'(model_count)) e.status = ST_RANGE;
            else e.read_value = model_store[r.idx];
         end
      endcase
      e.count = model_count;
      expected_results.push_back(e);
   endtask

   // Request driver: a new request may be presented whenever the previous
   // one has been taken, including the cycle in which the result shows.
   always @(posedge clock) begin
      request_type next_req;
      int          idle_pct;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) predict_result({req_action, req_value, req_index});
         if (!start || !busy) begin
            if (sent_reqs < total_reqs / 3) idle_pct = 38;
            else if (sent_reqs < 2 * total_reqs / 3) idle_pct = 59;
            else idle_pct = 0;
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
               next_req = pending_reqs.pop_front();
               req_action <= next_req.action;
               req_value  <= next_req.value;
               req_index  <= next_req.idx;
               start      <= 1'b1;
               sent_reqs  <= sent_reqs + 1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      list_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: read_value %h status %0d count %0d", $time,
                     rsp_read_value, rsp_status, rsp_count);
            error_count++;
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_read_value !== exp_res.read_value) begin
               $display("%0t: read_value mismatch: expected %h actual %h", $time,
                        exp_res.read_value, rsp_read_value);
               error_count++;
            end
            if (rsp_status !== exp_res.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d", $time,
                        exp_res.status, rsp_status);
               error_count++;
            end
            if (rsp_count !== exp_res.count) begin
               $display("%0t: count mismatch: expected %0d actual %0d", $time,
                        exp_res.count, rsp_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(negedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int sz;
      int r;
      int app_w;
      int rest;
      int n;
      int random_made;
      logic [ACTION_W-1:0] act;
      logic [VALUE_W-1:0]  val;
      logic [INDEX_W-1:0]  pos;

      value_pool[0] = '0;
      value_pool[1] = '1;
      for (n = 2; n < 8; n++) value_pool[n] = $urandom;

      // Operations on an empty list all fail.
      add_request(ACT_READ, '0, 6'd0);
      add_request(ACT_DEL_VALUE, '0, 6'd0);
      add_request(ACT_DEL_INDEX, '0, 6'd0);
      add_request(ACT_APPEND, 32'h0000_0000, 6'd0);
      add_request(ACT_APPEND, 32'hFFFF_FFFF, 6'd63);
      add_request(ACT_APPEND, 32'h0000_0005, 6'd0);
      add_request(ACT_APPEND, 32'h0000_0000, 6'd0);
      add_request(ACT_READ, '0, 6'd0);
      add_request(ACT_READ, '1, 6'd1);
      add_request(ACT_READ, '0, 6'd3);
      add_request(ACT_READ, '0, 6'd4);
      add_request(ACT_READ, '0, 6'd63);
      // Duplicate zero: only the first copy goes.
      add_request(ACT_DEL_VALUE, 32'h0000_0000, 6'd0);
      add_request(ACT_READ, '0, 6'd2);
      add_request(ACT_DEL_VALUE, 32'h1234_5678, 6'd0);
      add_request(ACT_DEL_INDEX, '0, 6'd2);
      add_request(ACT_DEL_INDEX, '0, 6'd5);
      add_request(ACT_APPEND, 32'hAAAA_AAAA, 6'd0);
      add_request(ACT_APPEND, 32'h5555_5555, 6'd0);
      add_request(ACT_DEL_INDEX, '0, 6'd0);
      add_request(ACT_DEL_VALUE, 32'h5555_5555, 6'd0);
      add_request(ACT_READ, '0, 6'd0);
      add_request(ACT_READ, '0, 6'd1);

      random_made = 0;
      while (random_made < RANDOM_ITEMS) begin
         r = $urandom_range(99);
         n = pending_reqs.size();
         if (r < 55) begin
            repeat (20) begin
               sz    = shadow_list.size();
               app_w = (sz < 16) ? 50 : ((sz > 48) ? 15 : 30);
               rest  = 100 - app_w;
               r     = $urandom_range(99);
               if (r < app_w) act = ACT_APPEND;
               else if (r < app_w + rest / 4) act = ACT_DEL_VALUE;
               else if (r < app_w + rest / 2) act = ACT_DEL_INDEX;
               else act = ACT_READ;
               if (sz > 0 && $urandom_range(9) < 8) pos = INDEX_W'($urandom_range(sz - 1));
               else pos = INDEX_W'($urandom_range(63));
               if (act == ACT_DEL_VALUE && sz > 0 && $urandom_range(9) < 6)
                  val = shadow_list[$urandom_range(sz - 1)];
               else val = pick_value();
               add_request(act, val, pos);
            end
         end else if (r < 67) begin
            // Fill to capacity, read the last slot, then push past full.
            while (shadow_list.size() < LIST_DEPTH) begin
               add_request(ACT_APPEND, pick_value(), INDEX_W'($urandom_range(63)));
            end
            add_request(ACT_READ, $urandom, 6'd63);
            repeat ($urandom_range(1, 3))
               add_request(ACT_APPEND, pick_value(), INDEX_W'($urandom_range(63)));
         end else if (r < 79) begin
            while (shadow_list.size() > 0) begin
               sz = shadow_list.size();
               if ($urandom_range(1))
                  add_request(ACT_DEL_INDEX, $urandom, INDEX_W'($urandom_range(sz - 1)));
               else
                  add_request(ACT_DEL_VALUE, shadow_list[$urandom_range(sz - 1)],
                              INDEX_W'($urandom));
            end
            add_request(ACT_DEL_VALUE, pick_value(), INDEX_W'($urandom));
            add_request(ACT_DEL_INDEX, $urandom, INDEX_W'($urandom_range(63)));
         end else begin
            repeat (10)
               add_request(ACTION_W'($urandom_range(3)), $urandom,
                           INDEX_W'($urandom_range(63)));
         end
         random_made += pending_reqs.size() - n;
      end
      total_reqs = pending_reqs.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || start || expected_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/cat_pkg.sv
src/cat_ctrl.sv
src/cat_datapath.sv
src/compacting_array_table.sv
tb/compacting_array_table_tb.sv
